// ===== rtl/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types and constants for the audio peak meter with hold and decay.
// ----------------------------------------------------------------------------
package apm_pkg;

    // item opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TICKS   = 2'd1;

    // register widths and reset values
    localparam int unsigned DECAY_BITS = 17;
    localparam int unsigned HOLD_TICKS_BITS = 16;
    localparam int unsigned CFG_DATA_BITS = 17;
    localparam int unsigned HOLD_BITS = 17;
    localparam int unsigned Q_BITS = 16;

    localparam logic [DECAY_BITS-1:0]      DECAY_RESET      = 17'd55706;
    localparam logic [HOLD_TICKS_BITS-1:0] HOLD_TICKS_RESET = 16'd40;
    localparam logic [DECAY_BITS-1:0]      UNITY_Q16        = 17'd65536;

    // control of one beat moving from the input register to the core
    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
    } apm_beat_t;

endpackage

// ===== rtl/apm_in_stage.sv =====
// ----------------------------------------------------------------------------
// apm_in_stage
// Input register: captures one beat and its sample magnitude.
// ----------------------------------------------------------------------------
module apm_in_stage
    import apm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    input  logic                          advance,
    output apm_beat_t                     beat,
    output logic [SAMPLE_BITS-1:0]        magnitude
);

    logic                   valid_reg;
    logic [1:0]             opcode_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag_next;
    logic                   take;

    // most negative sample wraps to full scale, which fits unsigned
    assign raw      = $unsigned(sample_value);
    assign mag_next = raw[SAMPLE_BITS-1] ? (~raw + {{(SAMPLE_BITS-1){1'b0}}, 1'b1}) : raw;

    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            opcode_reg <= opcode;
            mag_reg    <= mag_next;
        end
    end

    assign beat.valid  = valid_reg;
    assign beat.opcode = opcode_reg;
    assign magnitude   = mag_reg;

endmodule

// ===== rtl/apm_core.sv =====
// ----------------------------------------------------------------------------
// apm_core
// Meter state update; the state registers double as the result register.
// ----------------------------------------------------------------------------
module apm_core
    import apm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  apm_beat_t                  beat,
    input  logic [SAMPLE_BITS-1:0]     magnitude,
    output logic                       advance,
    input  logic [DECAY_BITS-1:0]      decay_factor,
    input  logic [HOLD_TICKS_BITS-1:0] hold_ticks,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [SAMPLE_BITS-1:0]     level,
    output logic [SAMPLE_BITS-1:0]     peak_level,
    output logic [SAMPLE_BITS-1:0]     session_max,
    output logic                       clip_seen
);

    localparam logic [SAMPLE_BITS-1:0] FullScale = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int unsigned ProdBits = SAMPLE_BITS + DECAY_BITS;

    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      level_reg;
    logic [SAMPLE_BITS-1:0]      level_next;
    logic [SAMPLE_BITS-1:0]      peak_reg;
    logic [SAMPLE_BITS-1:0]      peak_next;
    logic [SAMPLE_BITS-1:0]      max_reg;
    logic [SAMPLE_BITS-1:0]      max_next;
    logic                        clip_reg;
    logic                        clip_next;
    logic signed [HOLD_BITS-1:0] hold_reg;
    logic signed [HOLD_BITS-1:0] hold_next;

    logic [DECAY_BITS-1:0]  factor;
    logic [ProdBits-1:0]    product;
    logic [SAMPLE_BITS-1:0] level_raised;
    logic [SAMPLE_BITS-1:0] max_folded;

    assign advance = beat.valid && (!out_valid_reg || !out_stall);

    // factor above unity is clamped so a tick never raises the level
    assign factor  = (decay_factor > UNITY_Q16) ? UNITY_Q16 : decay_factor;
    assign product = ProdBits'(level_reg) * ProdBits'(factor);

    assign level_raised = (level_reg < magnitude) ? magnitude : level_reg;
    assign max_folded   = (max_reg < peak_reg) ? peak_reg : max_reg;

    always_comb
    begin
        level_next = level_reg;
        peak_next  = peak_reg;
        max_next   = max_reg;
        clip_next  = clip_reg;
        hold_next  = hold_reg;
        case (beat.opcode)
            OP_SAMPLE:
            begin
                level_next = level_raised;
                if ((peak_reg < level_raised) || hold_reg[HOLD_BITS-1])
                begin
                    peak_next = level_raised;
                    hold_next = $signed({1'b0, hold_ticks});
                end
            end
            OP_TICK:
            begin
                level_next = product[SAMPLE_BITS+Q_BITS-1:Q_BITS];
                // count down, stopping at minus one
                if (!hold_reg[HOLD_BITS-1])
                begin
                    hold_next = hold_reg - HOLD_BITS'(1);
                end
                max_next = max_folded;
                if (max_folded >= FullScale)
                begin
                    clip_next = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                level_next = '0;
                peak_next  = '0;
                max_next   = '0;
                clip_next  = 1'b0;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            peak_reg      <= '0;
            max_reg       <= '0;
            clip_reg      <= 1'b0;
            hold_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                peak_reg      <= peak_next;
                max_reg       <= max_next;
                clip_reg      <= clip_next;
                hold_reg      <= hold_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign level       = level_reg;
    assign peak_level  = peak_reg;
    assign session_max = max_reg;
    assign clip_seen   = clip_reg;

`ifndef SYNTH
    // clip flag tracks the maximum sitting at full scale
    a_clip_matches_max: assert property (@(posedge clk) disable iff (!rst_n)
        clip_reg == (max_reg == FullScale))
        else $error("clip flag out of step with session maximum");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg <= FullScale) && (peak_reg <= FullScale))
        else $error("level or peak beyond full scale");

    a_hold_floor: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg >= -HOLD_BITS'(1))
        else $error("hold countdown below minus one");

    a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (beat.opcode == OP_CLEAR)) |=>
            ((level_reg == '0) && (peak_reg == '0) && (max_reg == '0)))
        else $error("clear beat left state behind");

    a_tick_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (beat.opcode == OP_TICK)) |=> (level_reg <= $past(level_reg)))
        else $error("level grew on a tick");
`endif

endmodule

// ===== rtl/audio_peak_meter_hold_decay_top.sv =====
// ----------------------------------------------------------------------------
// audio_peak_meter_hold_decay_top
// Peak level meter with peak hold, per-tick decay and session maximum.
// ----------------------------------------------------------------------------
// Takes one beat per clock while out_stall is low and returns one result beat
// for every input beat, in order. A beat is registered on entry (with its
// sample magnitude) in the input register, then the meter state registers are
// updated from it and held as the result. The sustained rate of one beat per
// cycle, while the output is not stalled, is set by the state update loop:
// magnitude compare, peak reload and the decay multiply of the level by the
// Q1.16 factor. Configuration writes apply to beats that reach the state
// update after the write.
module audio_peak_meter_hold_decay_top
    import apm_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [SAMPLE_BITS-1:0]        level,
    output logic [SAMPLE_BITS-1:0]        peak_level,
    output logic [SAMPLE_BITS-1:0]        session_max,
    output logic                          clip_seen
);

    logic [DECAY_BITS-1:0]      decay_factor_reg;
    logic [HOLD_TICKS_BITS-1:0] hold_ticks_reg;
    apm_beat_t                  beat;
    logic [SAMPLE_BITS-1:0]     magnitude;
    logic                       advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_factor_reg <= DECAY_RESET;
            hold_ticks_reg   <= HOLD_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECAY_FACTOR: decay_factor_reg <= cfg_wdata[DECAY_BITS-1:0];
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_wdata[HOLD_TICKS_BITS-1:0];
                default:          decay_factor_reg <= decay_factor_reg;
            endcase
        end
    end

    apm_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .sample_value (sample_value),
        .advance      (advance),
        .beat         (beat),
        .magnitude    (magnitude)
    );

    apm_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat         (beat),
        .magnitude    (magnitude),
        .advance      (advance),
        .decay_factor (decay_factor_reg),
        .hold_ticks   (hold_ticks_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level        (level),
        .peak_level   (peak_level),
        .session_max  (session_max),
        .clip_seen    (clip_seen)
    );

endmodule
